// ===== design/periodic_event_timer_bank_macros.svh =====
// Assertion macros used by the timer bank top level.
`ifndef PERIODIC_EVENT_TIMER_BANK_MACROS_SVH
`define PERIODIC_EVENT_TIMER_BANK_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define PETB_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define PETB_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/petb_pkg.sv =====
// Package: constants, codes and shared types of the periodic event timer bank.
`timescale 1ns / 1ps
package petb_pkg;

  localparam int PETB_MAX_EVENTS = 8;

  localparam int PETB_OPCODE_W   = 2;
  localparam int PETB_EVENT_ID_W = 4;
  localparam int PETB_PERIOD_W   = 16;
  localparam int PETB_ASSIGN_W   = 3;
  localparam int PETB_MASK_W     = 8;

  localparam logic [PETB_OPCODE_W-1:0] OP_TICK = 2'd0;
  localparam logic [PETB_OPCODE_W-1:0] OP_ADD  = 2'd1;
  localparam logic [PETB_OPCODE_W-1:0] OP_SET  = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [PETB_PERIOD_W-1:0] ticks;
    logic                     fire;
  } petb_tick_res_t;

endpackage

// ===== design/petb_ifs.sv =====
// Interfaces: request and response channels of the timer bank.
`timescale 1ns / 1ps
interface petb_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [petb_pkg::PETB_OPCODE_W-1:0]   opcode;
  logic [petb_pkg::PETB_EVENT_ID_W-1:0] event_id;
  logic [petb_pkg::PETB_PERIOD_W-1:0]   period_value;

  modport source (output valid, opcode, event_id, period_value, input ready);
  modport sink (input valid, opcode, event_id, period_value, output ready);
endinterface

interface petb_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               status;
  logic [petb_pkg::PETB_ASSIGN_W-1:0] assigned_id;
  logic [petb_pkg::PETB_MASK_W-1:0]   fired_mask;

  modport source (output valid, status, assigned_id, fired_mask, input ready);
  modport sink (input valid, status, assigned_id, fired_mask, output ready);
endinterface

// ===== design/periodic_event_timer_bank.sv =====
// Top level: periodic event timer bank with sequenced slot walk.
`timescale 1ns / 1ps
// Bank of up to MAX_EVENTS periodic counters held in two small slot memories
// (period and tick count). Slots are handed out in order from 0 and never
// freed. An add, set-period or unused-opcode transaction, or a tick with no
// slots, goes from the result registers through the done state into the
// response register; the next transaction can be accepted once it is there.
// Other ticks take the same path after the slot walk. The sequencer walks the
// allocated slots one per cycle through the single increment-and-compare unit.
// The one read port of the slot memories feeds it, and read and write-back are
// overlapped. A response waits in its output register while the next
// transaction is accepted. A finished result that finds that register still
// full holds the block until the waiting response is taken. Only slots 0 to 7
// report in fired_mask, and assigned_id keeps its low 3 bits.
module periodic_event_timer_bank #(
  parameter int MAX_EVENTS = petb_pkg::PETB_MAX_EVENTS
) (
  input logic      clk,
  input logic      rst,
  petb_req_if.sink   req,
  petb_rsp_if.source rsp
);
  import petb_pkg::*;

  localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CNT_W = $clog2(MAX_EVENTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DONE
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     wb_idx;
  logic                 issuing;
  logic                 rd_vld;
  logic [PETB_PERIOD_W-1:0] rd_period;
  logic [PETB_PERIOD_W-1:0] rd_ticks;
  logic                     res_status;
  logic [PETB_ASSIGN_W-1:0] res_assigned;
  logic [PETB_MASK_W-1:0]   res_mask;
  logic                     out_valid;
  logic                     out_status;
  logic [PETB_ASSIGN_W-1:0] out_assigned;
  logic [PETB_MASK_W-1:0]   out_mask;

  logic [PETB_PERIOD_W-1:0] slot_period [MAX_EVENTS];
  logic [PETB_PERIOD_W-1:0] slot_ticks [MAX_EVENTS];

  logic                     accept;
  logic                     full;
  logic                     id_ok;
  logic                     add_ok;
  logic                     set_ok;
  logic                     rd_en;
  logic                     issue_last;
  logic                     wb_last;
  logic                     per_we;
  logic [IDX_W-1:0]         per_waddr;
  logic                     tk_we;
  logic [IDX_W-1:0]         tk_waddr;
  logic [PETB_PERIOD_W-1:0] tk_wdata;
  logic [4:0]               count_wide;
  logic [3:0]               wb_wide;
  logic [PETB_MASK_W-1:0]   fire_bit;
  petb_tick_res_t           alu_res;

  petb_tick_alu u_alu (
    .ticks  (rd_ticks),
    .period (rd_period),
    .res    (alu_res)
  );

  assign req.ready       = (state == S_IDLE);
  assign accept          = req.valid && req.ready;
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.assigned_id = out_assigned;
  assign rsp.fired_mask  = out_mask;

  assign count_wide = 5'(count);
  assign wb_wide    = 4'(wb_idx);
  assign full       = (count == CNT_W'(MAX_EVENTS));
  assign id_ok      = (5'(req.event_id) < count_wide);
  assign add_ok     = accept && (req.opcode == OP_ADD) && !full;
  assign set_ok     = accept && (req.opcode == OP_SET) && id_ok;
  assign rd_en      = (state == S_TICK) && issuing;
  assign issue_last = ((CNT_W'(rd_idx) + CNT_W'(1)) == count);
  assign wb_last    = ((CNT_W'(wb_idx) + CNT_W'(1)) == count);

  always_comb begin
    fire_bit = '0;
    if (alu_res.fire && !wb_wide[3]) begin
      fire_bit[wb_wide[2:0]] = 1'b1;
    end
  end

  assign per_we    = add_ok || set_ok;
  assign per_waddr = add_ok ? count[IDX_W-1:0] : req.event_id[IDX_W-1:0];
  assign tk_we     = add_ok || ((state == S_TICK) && rd_vld);
  assign tk_waddr  = add_ok ? count[IDX_W-1:0] : wb_idx;
  assign tk_wdata  = add_ok ? '0 : alu_res.ticks;

  always_ff @(posedge clk) begin
    if (per_we) begin
      slot_period[per_waddr] <= req.period_value;
    end
    if (tk_we) begin
      slot_ticks[tk_waddr] <= tk_wdata;
    end
    if (rd_en) begin
      rd_period <= slot_period[rd_idx];
      rd_ticks  <= slot_ticks[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      issuing   <= 1'b0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_status   <= STATUS_OK;
            res_assigned <= '0;
            res_mask     <= '0;
            state        <= S_DONE;
            unique case (req.opcode)
              OP_TICK: begin
                if (count != '0) begin
                  rd_idx  <= '0;
                  issuing <= 1'b1;
                  rd_vld  <= 1'b0;
                  state   <= S_TICK;
                end
              end
              OP_ADD: begin
                if (full) begin
                  res_status <= STATUS_ERR;
                end else begin
                  res_assigned <= count_wide[PETB_ASSIGN_W-1:0];
                  count        <= count + CNT_W'(1);
                end
              end
              OP_SET: begin
                res_status <= id_ok ? STATUS_OK : STATUS_ERR;
              end
              default: begin
              end
            endcase
          end
        end
        S_TICK: begin
          rd_vld <= issuing;
          if (issuing) begin
            wb_idx <= rd_idx;
            if (issue_last) begin
              issuing <= 1'b0;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
            end
          end
          if (rd_vld) begin
            res_mask <= res_mask | fire_bit;
            if (wb_last) begin
              rd_vld <= 1'b0;
              state  <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid    <= 1'b1;
            out_status   <= res_status;
            out_assigned <= res_assigned;
            out_mask     <= res_mask;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "periodic_event_timer_bank_macros.svh"

  `PETB_CHECK(count_bound, 1'b1, count <= CNT_W'(MAX_EVENTS), "slot count beyond bank size")
  `PETB_CHECK_NEXT(add_grows, add_ok, count == $past(count) + CNT_W'(1), "add did not take slot")
  `PETB_CHECK_NEXT(other_keeps, accept && !add_ok, $stable(count), "slot count moved")
  `PETB_CHECK(walk_in_range, (state == S_TICK) && rd_vld, CNT_W'(wb_idx) < count, "walk past end")

endmodule

// ===== design/petb_tick_alu.sv =====
// Shared tick unit: increment one slot count and compare it with its period.
`timescale 1ns / 1ps
module petb_tick_alu (
  input  logic [petb_pkg::PETB_PERIOD_W-1:0] ticks,
  input  logic [petb_pkg::PETB_PERIOD_W-1:0] period,
  output petb_pkg::petb_tick_res_t           res
);
  import petb_pkg::*;

  logic [PETB_PERIOD_W-1:0] incr;

  assign incr      = ticks + PETB_PERIOD_W'(1);
  assign res.fire  = (incr >= period);
  assign res.ticks = res.fire ? '0 : incr;

endmodule
